// ----- sv/uqn_pkg.sv -----
// shared types and constants for the utf-8 query normalizer
package uqn_pkg;

  // decoded code point, up to 21 bits from a four-byte sequence
  typedef logic [20:0] cp_t;
  // one utf-16 code unit
  typedef logic [15:0] unit_t;

  // code point transfer from the front end into the queue
  typedef struct packed {
    logic valid;
    cp_t  cp;
  } cp_push_t;

  // queue status seen by the back end
  typedef struct packed {
    logic not_empty;
    cp_t  head;
  } cp_head_t;

  // queue geometry
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // lead byte tags
  localparam logic [2:0] Lead2Tag = 3'b110;
  localparam logic [3:0] Lead3Tag = 4'b1110;
  localparam logic [4:0] Lead4Tag = 5'b11110;
  localparam logic [1:0] ContTag  = 2'b10;

  // surrogate construction
  localparam cp_t   SuppBase  = 21'h010000;
  localparam unit_t HighSurr  = 16'hD800;
  localparam unit_t LowSurr   = 16'hDC00;

  // case folding ranges
  localparam unit_t AsciiUpLo  = 16'h0041;
  localparam unit_t AsciiUpHi  = 16'h005A;
  localparam unit_t LatinUpLo  = 16'h00C0;
  localparam unit_t LatinUpHi  = 16'h00DE;
  localparam unit_t LatinTimes = 16'h00D7;
  localparam unit_t FoldOffset = 16'h0020;

endpackage

// ----- sv/uqn_front.sv -----
// front end: takes utf-8 bytes and assembles code points
module uqn_front import uqn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] byte_in,
  input  logic       last_byte,
  output cp_push_t   push
);

  logic [1:0] pending;
  logic [1:0] pending_next;
  cp_t        accum;
  cp_t        accum_next;
  logic       bad;
  logic       bad_next;
  logic [1:0] pending_dec;
  logic       bad_cont;

  assign pending_dec = pending - 2'd1;
  assign bad_cont    = bad | (byte_in[7:6] != ContTag);

  // sequence decode for one accepted byte
  always_comb begin
    pending_next = pending;
    accum_next   = accum;
    bad_next     = bad;
    push.valid   = 1'b0;
    push.cp      = {13'd0, byte_in};
    if (accept) begin
      if (pending == 2'd0) begin
        priority if (byte_in[7] == 1'b0) begin
          push.valid = 1'b1;
        end else if (byte_in[7:5] == Lead2Tag) begin
          accum_next   = {16'd0, byte_in[4:0]};
          pending_next = 2'd1;
          bad_next     = 1'b0;
        end else if (byte_in[7:4] == Lead3Tag) begin
          accum_next   = {17'd0, byte_in[3:0]};
          pending_next = 2'd2;
          bad_next     = 1'b0;
        end else if (byte_in[7:3] == Lead4Tag) begin
          accum_next   = {18'd0, byte_in[2:0]};
          pending_next = 2'd3;
          bad_next     = 1'b0;
        end else begin
          // stray continuation or 0xf8..0xff lead: skipped
          pending_next = pending;
        end
      end else begin
        accum_next   = {accum[14:0], byte_in[5:0]};
        bad_next     = bad_cont;
        pending_next = pending_dec;
        if (pending_dec == 2'd0) begin
          push.valid = !bad_cont;
          push.cp    = {accum[14:0], byte_in[5:0]};
          accum_next = '0;
          bad_next   = 1'b0;
        end
      end
      // end of query drops any open sequence
      if (last_byte) begin
        pending_next = 2'd0;
        accum_next   = '0;
        bad_next     = 1'b0;
      end
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
      accum   <= '0;
      bad     <= 1'b0;
    end else begin
      pending <= pending_next;
      accum   <= accum_next;
      bad     <= bad_next;
    end
  end

endmodule

// ----- sv/uqn_queue.sv -----
// short code point queue between front and back ends
module uqn_queue import uqn_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cp_push_t push,
  input  logic     pop,
  output cp_head_t head,
  output logic     full
);

  cp_t              entries [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;
  logic             do_pop;

  assign do_pop         = pop && (count != '0);
  assign full           = (count == QCntW'(QDepth));
  assign head.not_empty = (count != '0);
  assign head.head      = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.cp;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPtrW'(1);
      end
      unique case ({push.valid, do_pop})
        2'b10:   count <= count + QCntW'(1);
        2'b01:   count <= count - QCntW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/uqn_back.sv -----
// back end: splits code points into utf-16 units and folds case
module uqn_back import uqn_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_write,
  input  logic     cfg_data,
  input  cp_head_t head,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_ready,
  output unit_t    code_unit,
  output logic     last_of_run
);

  typedef enum logic [1:0] {
    PH_FIRST  = 2'b01,
    PH_SECOND = 2'b10
  } phase_t;

  phase_t phase;
  phase_t phase_next;
  logic   exact_case;
  logic   load;
  logic   is_pair;
  cp_t    offs;
  unit_t  hi_unit;
  unit_t  lo_unit;
  unit_t  raw_unit;
  logic   raw_last;

  function automatic unit_t fold_unit(unit_t u, logic exact);
    unit_t r;
    r = u;
    if (!exact) begin
      if (u >= AsciiUpLo && u <= AsciiUpHi) begin
        r = u + FoldOffset;
      end else if (u >= LatinUpLo && u <= LatinUpHi && u != LatinTimes) begin
        r = u + FoldOffset;
      end
    end
    return r;
  endfunction

  assign load    = head.not_empty && (!out_valid || out_ready);
  assign is_pair = (head.head >= SuppBase);
  assign offs    = head.head - SuppBase;
  assign hi_unit = HighSurr + {5'd0, offs[20:10]};
  assign lo_unit = LowSurr + {6'd0, offs[9:0]};

  // pick the unit for this cycle
  always_comb begin
    phase_next = phase;
    pop        = 1'b0;
    raw_unit   = head.head[15:0];
    raw_last   = 1'b1;
    if (load) begin
      if (is_pair) begin
        unique case (phase)
          PH_FIRST: begin
            raw_unit   = hi_unit;
            raw_last   = 1'b0;
            phase_next = PH_SECOND;
          end
          PH_SECOND: begin
            raw_unit   = lo_unit;
            pop        = 1'b1;
            phase_next = PH_FIRST;
          end
          default: begin
            phase_next = PH_FIRST;
          end
        endcase
      end else begin
        pop = 1'b1;
      end
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      exact_case <= 1'b0;
    end else if (cfg_write) begin
      exact_case <= cfg_data;
    end
  end

  // pair phase and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_FIRST;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      code_unit   <= fold_unit(raw_unit, exact_case);
      last_of_run <= raw_last;
    end
  end

endmodule

// ----- sv/utf8_query_normalizer_unit.sv -----
// top level of the utf-8 query normalizer
// Takes one UTF-8 byte per cycle while in_ready is high and delivers UTF-16
// code units, case folded unless exact_case is set. The front end accepts a
// byte every cycle as long as its four-entry code point queue has room; the
// back end drains the queue through a registered output at one unit per
// cycle while out_ready is high, so a code point below 0x10000 yields one
// unit and a four-byte sequence yields a surrogate pair. The output unit is
// registered from the code point at the queue head. Invalid leads, bad
// continuations and sequences cut off by last_byte produce nothing.
module utf8_query_normalizer_unit import uqn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_in,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] code_unit,
  output logic        last_of_run
);

  cp_push_t push;
  cp_head_t head;
  logic     full;
  logic     pop;
  logic     accept;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  uqn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .byte_in   (byte_in),
    .last_byte (last_byte),
    .push      (push)
  );

  uqn_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (full)
  );

  uqn_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_unit   (code_unit),
    .last_of_run (last_of_run)
  );

endmodule
